/* hdl/grmc_pkg.sv */
// ----------------------------------------------------------------------------
// grmc_pkg
// types, constants and trig table for the column ray caster
// ----------------------------------------------------------------------------
package grmc_pkg;

    localparam int MapWidth   = 160;
    localparam int MapHeight  = 120;
    localparam int NumColumns = 160;
    localparam int Cells      = MapWidth * MapHeight;
    localparam int AddrW      = $clog2(Cells);
    localparam int FullTurn   = 2880;
    localparam int Quarter    = 720;
    localparam int ScreenRows = 120;

    localparam logic [1:0] RegPlayerX  = 2'd0;
    localparam logic [1:0] RegPlayerY  = 2'd1;
    localparam logic [1:0] RegAngle    = 2'd2;
    localparam logic [1:0] RegMaxSteps = 2'd3;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdCast = 1'b1;

    typedef struct packed {
        logic        command;
        logic [14:0] cell_index;
        logic [23:0] cell_color;
        logic [7:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_column;
        logic        hit;
        logic [13:0] distance_steps;
        logic [6:0]  wall_height;
        logic [23:0] wall_color;
    } t_out_item;

    // quarter-wave sine entry, step units of 2^-24 cell
    function automatic logic [17:0] quarter_rom(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        begin
            x    = (64'(k) * 64'd1686629713) / 64'd720;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > 64'sd1073741824) sum = 64'sd1073741824;
            quarter_rom = 18'((sum + 3200) / 6400);
        end
    endfunction

endpackage

/* hdl/grid_ray_march_column_caster_unit.sv */
// ----------------------------------------------------------------------------
// grid_ray_march_column_caster_unit
// load: busy stays low. cast: result strobe after states S_TRIG, S_MARCH,
// S_DRAIN, S_DIV and S_OUT, with a hit or without; one march step per cycle,
// set by the single map read port; busy high until the strobe
// synchronous active-low reset empties the map by a clearing pass over all
// 19200 cells (one cell a cycle) during which busy stays high
// ----------------------------------------------------------------------------
module grid_ray_march_column_caster_unit
    import grmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_TRIG = 7'b0000100,
        S_MARCH = 7'b0001000, S_DRAIN = 7'b0010000, S_DIV = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [23:0]        r_px_cfg, r_py_cfg;
    logic [8:0]         r_ang_cfg;
    logic [13:0]        r_max_cfg;
    logic [AddrW-1:0]   r_clr;
    logic [23:0]        mem [0:Cells-1];
    logic [23:0]        r_rd;
    logic               r_rd_ok;
    logic [13:0]        r_rd_step;
    logic [7:0]         r_col;
    logic [11:0]        r_ang;
    logic signed [35:0] r_px, r_py;
    logic signed [25:0] dx, dy;
    logic [13:0]        r_step;
    logic               r_hit;
    logic [13:0]        r_dist;
    logic [23:0]        r_color;
    logic [6:0]         r_quo;
    logic [2:0]         r_bit;
    logic               r_strobe;

    logic               cfg_wr;
    logic signed [35:0] npx, npy;
    logic               in_map;
    logic [AddrW-1:0]   rd_addr;
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    logic [23:0]        wr_data;
    logic [12:0]        ang_c;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    always_comb begin
        unique case (paddr[3:2])
            RegPlayerX:  prdata = {8'd0, r_px_cfg};
            RegPlayerY:  prdata = {8'd0, r_py_cfg};
            RegAngle:    prdata = {23'd0, r_ang_cfg};
            RegMaxSteps: prdata = {18'd0, r_max_cfg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_cfg <= 24'd5177344; r_py_cfg <= 24'd3866624;
            r_ang_cfg <= '0; r_max_cfg <= 14'd10000;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                RegPlayerX:  r_px_cfg  <= pwdata[23:0];
                RegPlayerY:  r_py_cfg  <= pwdata[23:0];
                RegAngle:    r_ang_cfg <= pwdata[8:0];
                RegMaxSteps: r_max_cfg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    grmc_wave u_cos (.i_clk(i_clk),
        .i_angle(r_ang >= 12'(FullTurn - Quarter) ? r_ang - 12'(FullTurn - Quarter)
                                                   : r_ang + 12'(Quarter)),
        .o_value(dx));
    grmc_wave u_sin (.i_clk(i_clk), .i_angle(r_ang), .o_value(dy));

    assign busy = (r_state != S_IDLE);
    assign npx  = r_px + 36'(dx);
    assign npy  = r_py + 36'(dy);
    assign in_map = !npx[35] && !npy[35] && (npx[35:24] < 12'(MapWidth))
                    && (npy[35:24] < 12'(MapHeight));
    assign rd_addr = AddrW'(npy[31:24] * MapWidth) + AddrW'(npx[34:24]);

    always_comb begin
        ang_c = 13'(r_ang_cfg) * 13'd8 + 13'(3 * i_item.column);
        ang_c = ang_c + 13'(FullTurn - 240);
        priority if (ang_c >= 13'(2 * FullTurn)) ang_c = ang_c - 13'(2 * FullTurn);
        else if (ang_c >= 13'(FullTurn)) ang_c = ang_c - 13'(FullTurn);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == S_IDLE && start && i_item.command == CmdLoad
                     && i_item.cell_index < 15'(Cells)) begin
            wr_en   = 1'b1;
            wr_addr = AddrW'(i_item.cell_index);
            wr_data = i_item.cell_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AddrW'(Cells - 1)) n_state = S_IDLE;
            S_IDLE:  if (start && i_item.command == CmdCast) n_state = S_TRIG;
            S_TRIG:  n_state = S_MARCH;
            S_MARCH: if ((r_rd_ok && r_rd != 24'd0) || r_step == r_max_cfg)
                         n_state = S_DRAIN;
            S_DRAIN: n_state = S_DIV;
            S_DIV:   if (!r_hit || r_bit == 3'd0) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // march: a read issued for step s is checked in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_strobe <= 1'b0; r_rd_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_col <= i_item.column; r_ang <= ang_c[11:0];
                    r_px <= {4'd0, r_px_cfg, 8'd0}; r_py <= {4'd0, r_py_cfg, 8'd0};
                    r_step <= '0; r_rd_ok <= 1'b0; r_hit <= 1'b0;
                end
                S_TRIG: ;
                S_MARCH: begin
                    if (r_rd_ok && r_rd != 24'd0) begin
                        r_hit <= 1'b1; r_dist <= r_rd_step; r_color <= r_rd;
                        r_rd_ok <= 1'b0;
                    end else if (r_step == r_max_cfg) begin
                        r_rd_ok <= 1'b0;
                    end else begin
                        r_px <= npx; r_py <= npy;
                        r_step <= r_step + 1'b1;
                        r_rd_ok <= in_map; r_rd_step <= r_step + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_hit && r_rd_ok && r_rd != 24'd0) begin
                        r_hit <= 1'b1; r_dist <= r_rd_step; r_color <= r_rd;
                    end
                    r_rd_ok <= 1'b0;
                    r_quo <= '0; r_bit <= 3'd7;
                end
                S_DIV: begin
                    if (!r_hit) begin
                        r_dist <= r_max_cfg; r_color <= '0; r_quo <= '0;
                    end else begin
                        // trial-multiply division of 12000 by steps, one quotient bit a cycle
                        if (r_dist <= 14'(12000 / 128)) begin
                            r_quo <= 7'(ScreenRows);
                        end else if (24'({r_quo | (7'd1 << (r_bit - 3'd1))}) * 24'(r_dist)
                                     <= 24'd12000) begin
                            r_quo <= r_quo | (7'd1 << (r_bit - 3'd1));
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_OUT: r_strobe <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    always_comb begin
        o_item.out_column     = r_col;
        o_item.hit            = r_hit;
        o_item.distance_steps = r_dist;
        o_item.wall_height    = (r_hit && r_quo > 7'(ScreenRows)) ? 7'(ScreenRows)
                                : (r_hit ? r_quo : 7'd0);
        o_item.wall_color     = r_hit ? r_color : 24'd0;
    end
endmodule

/* hdl/grmc_wave.sv */
// ----------------------------------------------------------------------------
// grmc_wave
// registered signed sine lookup over a full turn in eighths of a degree
// ----------------------------------------------------------------------------
module grmc_wave
    import grmc_pkg::*;
(
    input  logic               i_clk,
    input  logic [11:0]        i_angle,
    output logic signed [25:0] o_value
);
    logic [17:0] rom [0:Quarter];
    logic [11:0] idx;
    logic [1:0]  q;
    logic [9:0]  r;
    logic [17:0] v;

    always_comb begin
        for (int k = 0; k <= Quarter; k++) rom[k] = quarter_rom(k);
    end

    always_comb begin
        if (i_angle >= 12'(3 * Quarter)) begin
            q = 2'd3; r = 10'(i_angle - 12'(3 * Quarter));
        end else if (i_angle >= 12'(2 * Quarter)) begin
            q = 2'd2; r = 10'(i_angle - 12'(2 * Quarter));
        end else if (i_angle >= 12'(Quarter)) begin
            q = 2'd1; r = 10'(i_angle - 12'(Quarter));
        end else begin
            q = 2'd0; r = 10'(i_angle);
        end
        idx = q[0] ? 12'(Quarter) - 12'(r) : 12'(r);
        v   = rom[idx[9:0]];
    end

    always_ff @(posedge i_clk) begin
        o_value <= q[1] ? -$signed({8'd0, v}) : $signed({8'd0, v});
    end
endmodule

/* hdl/grmc_checker.sv */
// ----------------------------------------------------------------------------
// grmc_checker
// port-level checks of the caster handshake and results
// ----------------------------------------------------------------------------
module grmc_checker
    import grmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_item,
    input logic      pready
);
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe repeated");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_item.hit) |-> (o_item.wall_color == 0 && o_item.wall_height == 0))
        else $error("empty ray drew");
    a_height_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_item.wall_height <= 7'(ScreenRows)) else $error("height");
    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind grid_ray_march_column_caster_unit grmc_checker u_grmc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_strobe(o_strobe),
    .o_item(o_item), .pready(pready));
